>>> hdl/tpmn_pkg.sv
// ----------------------------------------------------------------------------
// tpmn_pkg
// Shared widths, opcodes and word types of the TPM normalizer.
// ----------------------------------------------------------------------------
package tpmn_pkg;

   localparam int OP_W       = 2;
   localparam int COUNT_W    = 32;
   localparam int INV_W      = 33;
   localparam int TPM_W      = 32;
   localparam int TOTAL_W    = 24;

   localparam int RPK_FRAC_W = 16;
   localparam int RPK_W      = COUNT_W + INV_W - RPK_FRAC_W;
   localparam int SUM_W      = 64;
   localparam int NUM_FRAC_W = 12;
   localparam int NUM_W      = TOTAL_W + NUM_FRAC_W;
   localparam int MANT_W     = 56;
   localparam int SHIFT_W    = 7;
   localparam int PROD_W     = RPK_W + MANT_W;
   localparam int A_LO_W     = 25;
   localparam int B_LO_W     = 28;

   localparam int QUEUE_DEPTH  = 4;
   localparam int RESULT_DEPTH = 2;

   localparam logic [OP_W-1:0] OP_ACCUM  = 2'd0;
   localparam logic [OP_W-1:0] OP_FINISH = 2'd1;
   localparam logic [OP_W-1:0] OP_SCALE  = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam logic [TOTAL_W-1:0] TOTAL_RESET = 24'd1000000;
   localparam logic [SHIFT_W-1:0] SHIFT_MAX   = '1;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [COUNT_W-1:0] count;
      logic [INV_W-1:0]   recip_len;
   } tpmn_req_type;

   typedef struct packed {
      logic [TPM_W-1:0] tpm;
      logic             status;
   } tpmn_rsp_type;

   typedef struct packed {
      logic               status;
      logic [SHIFT_W-1:0] shift;
      logic [MANT_W-1:0]  mant;
   } tpmn_factor_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [SHIFT_W-1:0] shift;
      logic [MANT_W-1:0]  mant;
   } tpmn_div_type;

   typedef struct packed {
      logic issue;
      logic finish;
      logic pipe_busy;
      logic div_busy;
   } tpmn_back_stat_type;

endpackage

>>> hdl/tpmn_fifo.sv
// ----------------------------------------------------------------------------
// tpmn_fifo
// Small register queue, DEPTH of at least 2 words.
// ----------------------------------------------------------------------------
module tpmn_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/tpmn_front.sv
// ----------------------------------------------------------------------------
// tpmn_front
// Input register: takes request words, drops the unused opcode and hands
// the rest to the work queue.
// ----------------------------------------------------------------------------
module tpmn_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  tpmn_pkg::tpmn_req_type req_word,
   output logic                   req_full,
   output logic                   q_push,
   output tpmn_pkg::tpmn_req_type q_item,
   input  logic                   q_full
);

   logic                   vld_ff, vld_in;
   tpmn_pkg::tpmn_req_type item_ff, item_in;
   logic                   accept;

   assign req_full = vld_ff && q_full;
   assign accept   = req_push && !req_full;
   assign q_push   = vld_ff && !q_full;
   assign q_item   = item_ff;

   always_comb begin
      vld_in  = vld_ff;
      item_in = item_ff;
      if (accept) begin
         vld_in  = (req_word.op != tpmn_pkg::OP_UNUSED);
         item_in = req_word;
      end else if (q_push) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

>>> hdl/tpmn_divider.sv
// ----------------------------------------------------------------------------
// tpmn_divider
// Bit-serial restoring divider for the column factor: integer quotient of
// the numerator first, then fraction bits until mantissa MSB or SHIFT_MAX.
// ----------------------------------------------------------------------------
module tpmn_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [tpmn_pkg::SUM_W-1:0]       denom,
   input  logic [tpmn_pkg::NUM_W-1:0]       num,
   output tpmn_pkg::tpmn_div_type           result
);

   localparam int SUM_W   = tpmn_pkg::SUM_W;
   localparam int NUM_W   = tpmn_pkg::NUM_W;
   localparam int MANT_W  = tpmn_pkg::MANT_W;
   localparam int SHIFT_W = tpmn_pkg::SHIFT_W;
   localparam int CNT_W   = $clog2(NUM_W);

   localparam logic [1:0] DIV_IDLE = 2'd0;
   localparam logic [1:0] DIV_INT  = 2'd1;
   localparam logic [1:0] DIV_FRAC = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [SUM_W-1:0]   rem_ff, rem_in;
   logic [SUM_W-1:0]   denom_ff, denom_in;
   logic [MANT_W-1:0]  quo_ff, quo_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;

   logic               bit_in;
   logic [SUM_W:0]     rem_sh;
   logic [SUM_W:0]     rem_sub;
   logic               ge;
   logic [SUM_W-1:0]   rem_step;
   logic [MANT_W-1:0]  quo_step;
   logic               norm;

   always_comb begin
      bit_in   = (state_ff == DIV_INT) ? num_ff[NUM_W-1] : 1'b0;
      rem_sh   = {rem_ff, bit_in};
      rem_sub  = rem_sh - {1'b0, denom_ff};
      ge       = (rem_sh >= {1'b0, denom_ff});
      rem_step = ge ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
      quo_step = {quo_ff[MANT_W-2:0], ge};
      norm     = quo_ff[MANT_W-1] || (shift_ff == tpmn_pkg::SHIFT_MAX);

      state_in = state_ff;
      rem_in   = rem_ff;
      denom_in = denom_ff;
      quo_in   = quo_ff;
      num_in   = num_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;

      unique case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               state_in = DIV_INT;
               rem_in   = '0;
               quo_in   = '0;
               num_in   = num;
               denom_in = denom;
               cnt_in   = '0;
               shift_in = '0;
            end
         end
         DIV_INT: begin
            rem_in = rem_step;
            quo_in = quo_step;
            num_in = {num_ff[NUM_W-2:0], 1'b0};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               state_in = DIV_FRAC;
            end
         end
         DIV_FRAC: begin
            if (norm) begin
               state_in = DIV_IDLE;
            end else begin
               rem_in   = rem_step;
               quo_in   = quo_step;
               shift_in = shift_ff + SHIFT_W'(1);
            end
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   assign result.busy  = (state_ff != DIV_IDLE);
   assign result.done  = (state_ff == DIV_FRAC) && norm;
   assign result.shift = shift_ff;
   assign result.mant  = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      denom_ff <= denom_in;
      quo_ff   <= quo_in;
      num_ff   <= num_in;
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
   end

endmodule

>>> hdl/tpmn_back.sv
// ----------------------------------------------------------------------------
// tpmn_back
// Execution side: rpk multiply, saturating column sum, factor division and
// a four-stage scale pipeline feeding the result queue.
// ----------------------------------------------------------------------------
module tpmn_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [tpmn_pkg::TOTAL_W-1:0]      scale_total,
   input  logic                              q_valid,
   input  tpmn_pkg::tpmn_req_type            q_item,
   output logic                              q_pop,
   input  logic                              res_full,
   output logic                              res_push,
   output tpmn_pkg::tpmn_rsp_type            res_word,
   output tpmn_pkg::tpmn_back_stat_type      stat
);

   localparam int COUNT_W = tpmn_pkg::COUNT_W;
   localparam int INV_W   = tpmn_pkg::INV_W;
   localparam int MUL_W   = COUNT_W + INV_W;
   localparam int RPK_W   = tpmn_pkg::RPK_W;
   localparam int SUM_W   = tpmn_pkg::SUM_W;
   localparam int MANT_W  = tpmn_pkg::MANT_W;
   localparam int SHIFT_W = tpmn_pkg::SHIFT_W;
   localparam int PROD_W  = tpmn_pkg::PROD_W;
   localparam int TPM_W   = tpmn_pkg::TPM_W;
   localparam int A_LO_W  = tpmn_pkg::A_LO_W;
   localparam int A_HI_W  = RPK_W - A_LO_W;
   localparam int B_LO_W  = tpmn_pkg::B_LO_W;
   localparam int B_HI_W  = MANT_W - B_LO_W;
   localparam int P00_W   = A_LO_W + B_LO_W;
   localparam int P01_W   = A_LO_W + B_HI_W;
   localparam int P10_W   = A_HI_W + B_LO_W;
   localparam int P11_W   = A_HI_W + B_HI_W;

   // control
   logic                      adv;
   logic                      pipe_busy;
   logic                      is_fin;
   logic                      issue;
   logic                      fin_pop;
   logic                      div_start;
   tpmn_pkg::tpmn_div_type    div_res;

   // column state
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic                      sat_ff, sat_in;
   logic                      pend_sat_ff, pend_sat_in;
   tpmn_pkg::tpmn_factor_type sf_ff, sf_in;
   logic [SUM_W:0]            sum_ext;

   // stage 1
   logic                      v1_ff, v1_in;
   logic                      acc1_ff, acc1_in;
   logic [RPK_W-1:0]          rpk1_ff, rpk1_in;
   logic [MUL_W-1:0]          mul;

   // stage 2
   logic                      v2_ff, v2_in;
   logic [P00_W-1:0]          p00_ff, p00_in;
   logic [P01_W-1:0]          p01_ff, p01_in;
   logic [P10_W-1:0]          p10_ff, p10_in;
   logic [P11_W-1:0]          p11_ff, p11_in;
   logic [SHIFT_W-1:0]        k2_ff, k2_in;
   logic                      st2_ff, st2_in;

   // stage 3
   logic                      v3_ff, v3_in;
   logic [PROD_W-1:0]         lo3_ff, lo3_in;
   logic [PROD_W-1:0]         hi3_ff, hi3_in;
   logic [SHIFT_W-1:0]        k3_ff, k3_in;
   logic                      st3_ff, st3_in;

   // stage 4
   logic                      v4_ff, v4_in;
   logic [PROD_W-1:0]         full4_ff, full4_in;
   logic [SHIFT_W-1:0]        k4_ff, k4_in;
   logic                      st4_ff, st4_in;

   logic [PROD_W-1:0]         shifted;

   assign pipe_busy = v1_ff || v2_ff || v3_ff || v4_ff;
   assign adv       = !(v4_ff && res_full);
   assign is_fin    = (q_item.op == tpmn_pkg::OP_FINISH);
   assign issue     = q_valid && !div_res.busy && adv && !is_fin;
   assign fin_pop   = q_valid && !div_res.busy && is_fin && !pipe_busy;
   assign q_pop     = issue || fin_pop;
   assign div_start = fin_pop && (sum_ff != '0);

   assign stat.issue     = issue;
   assign stat.finish    = fin_pop;
   assign stat.pipe_busy = pipe_busy;
   assign stat.div_busy  = div_res.busy;

   tpmn_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .denom  (sum_ff),
      .num    ({scale_total, {tpmn_pkg::NUM_FRAC_W{1'b0}}}),
      .result (div_res)
   );

   // column sum and factor
   always_comb begin
      sum_ext     = {1'b0, sum_ff} + (SUM_W + 1)'(rpk1_ff);
      sum_in      = sum_ff;
      sat_in      = sat_ff;
      pend_sat_in = pend_sat_ff;
      sf_in       = sf_ff;
      if (adv && v1_ff && acc1_ff) begin
         if (sum_ext[SUM_W]) begin
            sum_in = '1;
            sat_in = 1'b1;
         end else begin
            sum_in = sum_ext[SUM_W-1:0];
         end
      end
      if (fin_pop) begin
         sum_in      = '0;
         sat_in      = 1'b0;
         pend_sat_in = sat_ff;
         if (sum_ff == '0) begin
            sf_in        = '0;
            sf_in.status = sat_ff;
         end
      end
      if (div_res.done) begin
         sf_in.status = pend_sat_ff;
         sf_in.shift  = div_res.shift;
         sf_in.mant   = div_res.mant;
      end
   end

   // scale pipeline
   always_comb begin
      mul = MUL_W'(q_item.count) * MUL_W'(q_item.recip_len);

      v1_in    = v1_ff;
      acc1_in  = acc1_ff;
      rpk1_in  = rpk1_ff;
      v2_in    = v2_ff;
      p00_in   = p00_ff;
      p01_in   = p01_ff;
      p10_in   = p10_ff;
      p11_in   = p11_ff;
      k2_in    = k2_ff;
      st2_in   = st2_ff;
      v3_in    = v3_ff;
      lo3_in   = lo3_ff;
      hi3_in   = hi3_ff;
      k3_in    = k3_ff;
      st3_in   = st3_ff;
      v4_in    = v4_ff;
      full4_in = full4_ff;
      k4_in    = k4_ff;
      st4_in   = st4_ff;

      if (adv) begin
         v1_in   = issue;
         acc1_in = (q_item.op == tpmn_pkg::OP_ACCUM);
         rpk1_in = mul[MUL_W-1:tpmn_pkg::RPK_FRAC_W];

         v2_in  = v1_ff && !acc1_ff;
         p00_in = P00_W'(rpk1_ff[A_LO_W-1:0]) * P00_W'(sf_ff.mant[B_LO_W-1:0]);
         p01_in = P01_W'(rpk1_ff[A_LO_W-1:0]) * P01_W'(sf_ff.mant[MANT_W-1:B_LO_W]);
         p10_in = P10_W'(rpk1_ff[RPK_W-1:A_LO_W]) * P10_W'(sf_ff.mant[B_LO_W-1:0]);
         p11_in = P11_W'(rpk1_ff[RPK_W-1:A_LO_W]) * P11_W'(sf_ff.mant[MANT_W-1:B_LO_W]);
         k2_in  = sf_ff.shift;
         st2_in = sf_ff.status;

         v3_in  = v2_ff;
         lo3_in = PROD_W'(p00_ff) + (PROD_W'(p01_ff) << B_LO_W);
         hi3_in = (PROD_W'(p11_ff) << (A_LO_W + B_LO_W)) + (PROD_W'(p10_ff) << A_LO_W);
         k3_in  = k2_ff;
         st3_in = st2_ff;

         v4_in    = v3_ff;
         full4_in = lo3_ff + hi3_ff;
         k4_in    = k3_ff;
         st4_in   = st3_ff;
      end
   end

   always_comb begin
      shifted         = full4_ff >> k4_ff;
      res_word.tpm    = (|shifted[PROD_W-1:TPM_W]) ? '1 : shifted[TPM_W-1:0];
      res_word.status = st4_ff;
      res_push        = v4_ff && adv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         sat_ff <= 1'b0;
         sf_ff  <= '0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
      end else begin
         sum_ff <= sum_in;
         sat_ff <= sat_in;
         sf_ff  <= sf_in;
         v1_ff  <= v1_in;
         v2_ff  <= v2_in;
         v3_ff  <= v3_in;
         v4_ff  <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_sat_ff <= pend_sat_in;
      acc1_ff     <= acc1_in;
      rpk1_ff     <= rpk1_in;
      p00_ff      <= p00_in;
      p01_ff      <= p01_in;
      p10_ff      <= p10_in;
      p11_ff      <= p11_in;
      k2_ff       <= k2_in;
      st2_ff      <= st2_in;
      lo3_ff      <= lo3_in;
      hi3_ff      <= hi3_in;
      k3_ff       <= k3_in;
      st3_ff      <= st3_in;
      full4_ff    <= full4_in;
      k4_ff       <= k4_in;
      st4_ff      <= st4_in;
   end

endmodule

>>> hdl/tpm_normalizer.sv
// ----------------------------------------------------------------------------
// tpm_normalizer
// Transcripts-per-million normalization of one sample column.
// ----------------------------------------------------------------------------
// Request words are pushed with req_push while req_full is low; each carries
// an opcode, a read count and a reciprocal gene length. Accumulate and finish
// give no response; each scale word gives one response word (tpm, status),
// read with rsp_pop while rsp_empty is low, oldest first. csr_write loads
// scale_total at once; write it only while the block is idle.
// Accumulate and scale words flow at one per cycle, unless a finish or a
// full result queue holds them, through a front register, a work queue and
// a four-stage multiply pipeline; scale results then enter the result queue.
// A finish waits until earlier words have left the pipeline, then the
// bit-serial divider runs 36 integer steps, 20 to 127 fraction steps and a
// closing step and holds later words until it is done; a finish of an
// empty column skips the divider.
// Reset clears the queues, the column sum and the factor and loads
// scale_total with one million. When the receiver stops popping, the result
// queue fills, the pipeline holds, and req_full rises once the work queue
// and the front register are full.
// ----------------------------------------------------------------------------
module tpm_normalizer #(
   parameter int QUEUE_DEPTH  = tpmn_pkg::QUEUE_DEPTH,
   parameter int RESULT_DEPTH = tpmn_pkg::RESULT_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   input  tpmn_pkg::tpmn_req_type        req_word,
   output logic                          req_full,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output tpmn_pkg::tpmn_rsp_type        rsp_word,
   input  logic                          csr_write,
   input  logic [tpmn_pkg::TOTAL_W-1:0]  csr_wdata
);

   localparam int REQ_W = $bits(tpmn_pkg::tpmn_req_type);
   localparam int RSP_W = $bits(tpmn_pkg::tpmn_rsp_type);

   logic [tpmn_pkg::TOTAL_W-1:0]  total_ff, total_in;
   logic                          fq_push;
   tpmn_pkg::tpmn_req_type        fq_item;
   logic                          fq_full;
   logic                          wq_empty;
   tpmn_pkg::tpmn_req_type        wq_item;
   logic                          wq_pop;
   logic                          res_push;
   logic                          res_full;
   tpmn_pkg::tpmn_rsp_type        res_word;
   tpmn_pkg::tpmn_back_stat_type  back_stat;

   assign total_in = csr_write ? csr_wdata : total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= tpmn_pkg::TOTAL_RESET;
      end else begin
         total_ff <= total_in;
      end
   end

   tpmn_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_word (req_word),
      .req_full (req_full),
      .q_push   (fq_push),
      .q_item   (fq_item),
      .q_full   (fq_full)
   );

   tpmn_fifo #(
      .WIDTH (REQ_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_work_q (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_data (fq_item),
      .full      (fq_full),
      .pop       (wq_pop),
      .pop_data  (wq_item),
      .empty     (wq_empty)
   );

   tpmn_back u_back (
      .clock       (clock),
      .reset       (reset),
      .scale_total (total_ff),
      .q_valid     (!wq_empty),
      .q_item      (wq_item),
      .q_pop       (wq_pop),
      .res_full    (res_full),
      .res_push    (res_push),
      .res_word    (res_word),
      .stat        (back_stat)
   );

   tpmn_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RESULT_DEPTH)
   ) u_result_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_word),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_word),
      .empty     (rsp_empty)
   );

   // nothing leaves the work queue while the divider owns the factor
   a_div_blocks_issue: assert property (@(posedge clock) disable iff (reset)
      back_stat.div_busy |-> !back_stat.issue && !back_stat.finish)
      else $error("word taken from work queue during division");

   // a finish sees the sum only after earlier accumulates have landed
   a_finish_drained: assert property (@(posedge clock) disable iff (reset)
      back_stat.finish |-> !back_stat.pipe_busy)
      else $error("finish taken with pipeline busy");

   // the pipeline holds instead of dropping a result
   a_result_room: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("result pushed into full queue");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not clear after reset");

endmodule
